@@ sv/vad_pkg.sv @@
// Package: word types, opcodes and shared constants of the vector ALU.
`timescale 1ns / 1ps
package vad_pkg;

   localparam int FIELD_BITS = 16;
   localparam int DIST_BITS  = 25;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_EQ   = 3'd4;
   localparam logic [2:0] OP_DIST = 3'd5;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [FIELD_BITS-1:0] a_x;
      logic [FIELD_BITS-1:0] a_y;
      logic [FIELD_BITS-1:0] a_z;
      logic [FIELD_BITS-1:0] b_x;
      logic [FIELD_BITS-1:0] b_y;
      logic [FIELD_BITS-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] res_x;
      logic [FIELD_BITS-1:0] res_y;
      logic [FIELD_BITS-1:0] res_z;
      logic                  equal;
      logic [DIST_BITS-1:0]  distance;
      logic                  div_by_zero;
   } rsp_type;

   // control that rides along the pipeline
   typedef struct packed {
      logic       valid;
      logic [2:0] opcode;
      logic       equal;
      logic       div_by_zero;
   } ctl_type;

endpackage

@@ sv/vad_prep.sv @@
// Front end: lane arithmetic, equality, squared differences and their sum.
`timescale 1ns / 1ps
module vad_prep
   import vad_pkg::*;
#(
   parameter int CW   = 16,
   parameter int RADW = 36
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           req_valid,
   input  req_type                        req_data,
   output ctl_type                        ctl_o,
   output logic [2:0][FIELD_BITS-1:0]     res_o,
   output logic [2:0][CW-1:0]             a_o,
   output logic [2:0][CW-1:0]             b_o,
   output logic [RADW-1:0]                rad_o
);

   localparam int SUMW = 2 * CW + 2;

   logic [2:0][CW-1:0]         a_in, b_in;
   logic [2:0][FIELD_BITS-1:0] res_in;
   logic [2:0][2*CW-1:0]       sq_in;
   ctl_type                    ctl_in;

   ctl_type                    ctl1_ff, ctl2_ff;
   logic [2:0][CW-1:0]         a1_ff, b1_ff, a2_ff, b2_ff;
   logic [2:0][FIELD_BITS-1:0] res1_ff, res2_ff;
   logic [2:0][2*CW-1:0]       sq1_ff;
   logic [RADW-1:0]            rad2_ff;
   logic [SUMW-1:0]            sum_in;

   always_comb begin
      logic [CW-1:0]   d;
      logic [CW-1:0]   r;
      logic [2*CW-1:0] p;
      a_in[0] = req_data.a_x[CW-1:0];
      a_in[1] = req_data.a_y[CW-1:0];
      a_in[2] = req_data.a_z[CW-1:0];
      b_in[0] = req_data.b_x[CW-1:0];
      b_in[1] = req_data.b_y[CW-1:0];
      b_in[2] = req_data.b_z[CW-1:0];
      for (int i = 0; i < 3; i++) begin
         d = (a_in[i] >= b_in[i]) ? a_in[i] - b_in[i] : b_in[i] - a_in[i];
         sq_in[i] = d * d;
         p = a_in[i] * b_in[i];
         case (req_data.opcode)
            OP_ADD:  r = a_in[i] + b_in[i];
            OP_SUB:  r = a_in[i] - b_in[i];
            OP_MUL:  r = p[CW-1:0];
            default: r = '0;
         endcase
         res_in[i] = FIELD_BITS'(r);
      end
      ctl_in.valid       = req_valid;
      ctl_in.opcode      = req_data.opcode;
      ctl_in.equal       = (req_data.opcode == OP_EQ) && (a_in == b_in);
      ctl_in.div_by_zero = (req_data.opcode == OP_DIV) &&
                           ((b_in[0] == '0) || (b_in[1] == '0) || (b_in[2] == '0));
   end

   assign sum_in = SUMW'(sq1_ff[0]) + SUMW'(sq1_ff[1]) + SUMW'(sq1_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl1_ff <= ctl_in;
         a1_ff   <= a_in;
         b1_ff   <= b_in;
         res1_ff <= res_in;
         sq1_ff  <= sq_in;
         ctl2_ff <= ctl1_ff;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         res2_ff <= res1_ff;
         // radicand is the sum scaled by 4^frac
         rad2_ff <= RADW'(sum_in) << (RADW - SUMW);
      end
   end

   assign ctl_o = ctl2_ff;
   assign res_o = res2_ff;
   assign a_o   = a2_ff;
   assign b_o   = b2_ff;
   assign rad_o = rad2_ff;

endmodule

@@ sv/vad_cell.sv @@
// One chain cell: a restoring divide step per lane (when DIV_EN is set) and one square root digit.
`timescale 1ns / 1ps
module vad_cell
   import vad_pkg::*;
#(
   parameter int CW     = 16,
   parameter int RB     = 25,
   parameter bit DIV_EN = 1'b1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  ctl_type                    ctl_i,
   input  logic [2:0][FIELD_BITS-1:0] res_i,
   input  logic [2:0][CW-1:0]         b_i,
   input  logic [2:0][CW-1:0]         rem_i,
   input  logic [2:0][CW-1:0]         dq_i,
   input  logic [2*RB-1:0]            rad_i,
   input  logic [RB-1:0]              root_i,
   input  logic [RB+1:0]              srem_i,
   output ctl_type                    ctl_o,
   output logic [2:0][FIELD_BITS-1:0] res_o,
   output logic [2:0][CW-1:0]         b_o,
   output logic [2:0][CW-1:0]         rem_o,
   output logic [2:0][CW-1:0]         dq_o,
   output logic [2*RB-1:0]            rad_o,
   output logic [RB-1:0]              root_o,
   output logic [RB+1:0]              srem_o
);

   logic [2:0][CW-1:0] rem_in, dq_in;
   logic [2*RB-1:0]    rad_in;
   logic [RB-1:0]      root_in;
   logic [RB+1:0]      srem_in;

   ctl_type                    ctl_ff;
   logic [2:0][FIELD_BITS-1:0] res_ff;
   logic [2:0][CW-1:0]         b_ff, rem_ff, dq_ff;
   logic [2*RB-1:0]            rad_ff;
   logic [RB-1:0]              root_ff;
   logic [RB+1:0]              srem_ff;

   always_comb begin
      logic [CW:0]   t, df;
      logic [RB+1:0] sr, trial;
      logic          ge;
      for (int i = 0; i < 3; i++) begin
         // zero divisor yields all ones without special handling
         t  = {rem_i[i], dq_i[i][CW-1]};
         df = t - {1'b0, b_i[i]};
         ge = (t >= {1'b0, b_i[i]});
         if (DIV_EN) begin
            rem_in[i] = ge ? df[CW-1:0] : t[CW-1:0];
            dq_in[i]  = {dq_i[i][CW-2:0], ge};
         end else begin
            rem_in[i] = rem_i[i];
            dq_in[i]  = dq_i[i];
         end
      end
      sr      = {srem_i[RB-1:0], rad_i[2*RB-1 -: 2]};
      trial   = {root_i, 2'b01};
      ge      = (sr >= trial);
      srem_in = ge ? sr - trial : sr;
      root_in = {root_i[RB-2:0], ge};
      rad_in  = rad_i << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff  <= ctl_i;
         res_ff  <= res_i;
         b_ff    <= b_i;
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
         rad_ff  <= rad_in;
         root_ff <= root_in;
         srem_ff <= srem_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign res_o  = res_ff;
   assign b_o    = b_ff;
   assign rem_o  = rem_ff;
   assign dq_o   = dq_ff;
   assign rad_o  = rad_ff;
   assign root_o = root_ff;
   assign srem_o = srem_ff;

endmodule

@@ sv/vector3_alu_with_distance.sv @@
// Top level: three-lane vector ALU with Euclidean distance.
//
// Request word: opcode plus vectors a and b on req_data, taken when req_valid
// is high and req_stall low. Opcodes: add, subtract, multiply (wrapping),
// divide (zero divisor gives all ones and div_by_zero), equality, distance.
// Response word on rsp_data with rsp_valid; the receiver holds it with
// rsp_stall. One response per request, in order.
// The pipeline holds two front stages, one chain cell per root digit (the
// divide steps share the first cells), and the output register. COORD_BITS
// is capped at 16 inside the lanes.
// Throughput is one word per cycle while not frozen; the whole chain advances together.
// When the output register holds a word and rsp_stall is high, the chain
// freezes and req_stall is raised in the same cycle.
// Reset clears all valid flags; no word is in flight afterwards.
`timescale 1ns / 1ps
module vector3_alu_with_distance
   import vad_pkg::*;
#(
   parameter int COORD_BITS     = 16,
   parameter int DIST_FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW   = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int RB   = CW + 1 + DIST_FRAC_BITS;
   localparam int RADW = 2 * RB;

   logic adv;

   ctl_type                    ctl     [0:RB];
   logic [2:0][FIELD_BITS-1:0] res     [0:RB];
   logic [2:0][CW-1:0]         b_s     [0:RB];
   logic [2:0][CW-1:0]         rem_s   [0:RB];
   logic [2:0][CW-1:0]         dq_s    [0:RB];
   logic [RADW-1:0]            rad_s   [0:RB];
   logic [RB-1:0]              root_s  [0:RB];
   logic [RB+1:0]              srem_s  [0:RB];

   logic    out_valid_ff;
   rsp_type out_ff;
   rsp_type out_in;

   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = !adv;

   vad_prep #(.CW(CW), .RADW(RADW)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .ctl_o     (ctl[0]),
      .res_o     (res[0]),
      .a_o       (dq_s[0]),
      .b_o       (b_s[0]),
      .rad_o     (rad_s[0])
   );

   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign srem_s[0] = '0;

   for (genvar k = 0; k < RB; k++) begin : g_cell
      vad_cell #(.CW(CW), .RB(RB), .DIV_EN(k < CW)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (ctl[k]),
         .res_i  (res[k]),
         .b_i    (b_s[k]),
         .rem_i  (rem_s[k]),
         .dq_i   (dq_s[k]),
         .rad_i  (rad_s[k]),
         .root_i (root_s[k]),
         .srem_i (srem_s[k]),
         .ctl_o  (ctl[k+1]),
         .res_o  (res[k+1]),
         .b_o    (b_s[k+1]),
         .rem_o  (rem_s[k+1]),
         .dq_o   (dq_s[k+1]),
         .rad_o  (rad_s[k+1]),
         .root_o (root_s[k+1]),
         .srem_o (srem_s[k+1])
      );
   end

   always_comb begin
      logic [2:0][FIELD_BITS-1:0] r;
      r = res[RB];
      if (ctl[RB].opcode == OP_DIV) begin
         for (int i = 0; i < 3; i++) begin
            r[i] = FIELD_BITS'(dq_s[RB][i]);
         end
      end
      out_in.res_x       = r[0];
      out_in.res_y       = r[1];
      out_in.res_z       = r[2];
      out_in.equal       = ctl[RB].equal;
      out_in.div_by_zero = ctl[RB].div_by_zero;
      out_in.distance    = (ctl[RB].opcode == OP_DIST) ? DIST_BITS'(root_s[RB]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= ctl[RB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request side not held while response is stalled");

   a_equal_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.equal) |->
      (rsp_data.res_x == '0 && rsp_data.res_y == '0 && rsp_data.res_z == '0 &&
       rsp_data.distance == '0 && !rsp_data.div_by_zero))
      else $error("equal word carries other results");

   a_dz_lane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_by_zero) |->
      (!rsp_data.equal && rsp_data.distance == '0))
      else $error("divide word carries compare or distance");

   a_dist_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.distance != '0) |->
      (rsp_data.res_x == '0 && rsp_data.res_y == '0 && rsp_data.res_z == '0))
      else $error("distance word carries lane results");

endmodule

@@ verif/tb.sv @@
// Testbench for the vector ALU: directed table plus random words, checked by a predictor.
`timescale 1ns / 1ps
module tb;
   import vad_pkg::*;

   localparam int LATENCY   = 28;
   localparam int N_RANDOM  = 1600;
   localparam int WDOG_MAX  = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_q[$];
   int      fail_count = 0;
   int      idle_cycles = 0;
   bit      stim_done = 1'b0;
   bit      hold_off = 1'b0;

   vector3_alu_with_distance i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // bit-serial integer square root of a 64-bit radicand
   function automatic logic [31:0] int_sqrt(input logic [63:0] radicand);
      logic [33:0] rem;
      logic [33:0] trial;
      logic [31:0] root;
      rem  = '0;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         rem   = {rem[31:0], radicand[2*i+1 -: 2]};
         trial = {root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[30:0], 1'b1};
         end else begin
            root = {root[30:0], 1'b0};
         end
      end
      return root;
   endfunction

   function automatic rsp_type alu_result(input req_type w);
      rsp_type r;
      logic [15:0] a [3];
      logic [15:0] b [3];
      logic [15:0] q [3];
      logic [63:0] sum;
      logic [16:0] d;
      r = '0;
      a = '{w.a_x, w.a_y, w.a_z};
      b = '{w.b_x, w.b_y, w.b_z};
      q = '{16'd0, 16'd0, 16'd0};
      sum = '0;
      case (w.opcode)
         OP_ADD: for (int i = 0; i < 3; i++) q[i] = a[i] + b[i];
         OP_SUB: for (int i = 0; i < 3; i++) q[i] = a[i] - b[i];
         OP_MUL: for (int i = 0; i < 3; i++) q[i] = a[i] * b[i];
         OP_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (b[i] == 0) begin
                  q[i] = 16'hFFFF;
                  r.div_by_zero = 1'b1;
               end else begin
                  q[i] = a[i] / b[i];
               end
            end
         end
         OP_EQ: r.equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
         OP_DIST: begin
            for (int i = 0; i < 3; i++) begin
               d = (a[i] >= b[i]) ? a[i] - b[i] : b[i] - a[i];
               sum += 64'(d) * 64'(d);
            end
            r.distance = 25'(int_sqrt(sum << 16));
         end
         default: ;
      endcase
      r.res_x = q[0];
      r.res_y = q[1];
      r.res_z = q[2];
      return r;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   // directed rows; has_rsp marks rows whose result is typed in
   typedef struct {
      req_type word;
      bit      has_rsp;
      rsp_type rsp;
   } row_type;
   row_type directed[$];

   task automatic add_row(input logic [2:0] op, input logic [15:0] ax, ay, az, bx, by, bz,
                          input bit has, input rsp_type r);
      row_type t;
      t.word    = '{op, ax, ay, az, bx, by, bz};
      t.has_rsp = has;
      t.rsp     = r;
      directed.push_back(t);
   endtask

   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(alu_result(w));
      @(negedge clock);
   endtask

   // directed table, then bursts of random words
   initial begin
      rsp_type none;
      req_type w;
      int burst;
      int gap;
      none = '0;
      add_row(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 1,
              '{16'h0000, 16'hFFFE, 16'hFFFF, 1'b0, 25'd0, 1'b0});
      add_row(OP_SUB, 16'h0000, 16'h0005, 16'hFFFF, 16'h0001, 16'h0005, 16'h0000, 1,
              '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 25'd0, 1'b0});
      add_row(OP_MUL, 16'hFFFF, 16'h0100, 16'h0003, 16'hFFFF, 16'h0100, 16'h0000, 1,
              '{16'h0001, 16'h0000, 16'h0000, 1'b0, 25'd0, 1'b0});
      add_row(OP_DIV, 16'hFFFF, 16'h0007, 16'h0009, 16'h0000, 16'h0002, 16'h0000, 1,
              '{16'hFFFF, 16'h0003, 16'hFFFF, 1'b0, 25'd0, 1'b1});
      add_row(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
              '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 25'd0, 1'b1});
      add_row(OP_DIV, 16'hFFFF, 16'h1234, 16'h0001, 16'hFFFF, 16'h0001, 16'h0002, 0, none);
      add_row(OP_EQ, 16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 16'h1234, 1,
              '{16'h0, 16'h0, 16'h0, 1'b1, 25'd0, 1'b0});
      add_row(OP_EQ, 16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 16'h1235, 1, none);
      add_row(OP_DIST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, none);
      add_row(OP_DIST, 16'h0003, 16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
              '{16'h0, 16'h0, 16'h0, 1'b0, 25'd1280, 1'b0});
      add_row(OP_DIST, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, none);
      add_row(OP_DIST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 0, none);
      add_row(OP_DIST, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 0, none);
      add_row(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, none);
      add_row(3'd7, 16'h1234, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, none);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_word(directed[i].word);
         if (directed[i].has_rsp && alu_result(directed[i].word) !== directed[i].rsp) begin
            $display("%0t table row %0d: expected %h, predictor %h", $time, i,
                     directed[i].rsp, alu_result(directed[i].word));
            fail_count++;
         end
      end

      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
            w.opcode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5));
            w.a_x = rand_coord(); w.a_y = rand_coord(); w.a_z = rand_coord();
            if (w.opcode == OP_EQ && $urandom_range(0, 1)) begin
               w.b_x = w.a_x; w.b_y = w.a_y; w.b_z = w.a_z;
               if ($urandom_range(0, 1)) w.b_z[$urandom_range(0, 15)] ^= 1'b1;
            end else begin
               w.b_x = rand_coord(); w.b_y = rand_coord(); w.b_z = rand_coord();
            end
            send_word(w);
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stall pattern, with one long hold-off partway through
   initial begin
      int mode;
      wait (!reset);
      repeat (300) @(negedge clock);
      hold_off = 1'b1;
      rsp_stall <= 1'b1;
      repeat (200) @(negedge clock);
      hold_off = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            rsp_stall <= (mode == 0) ? 1'b0 :
                         (mode == 1) ? ($urandom_range(0, 1) == 1) :
                         (mode == 2) ? ($urandom_range(0, 7) == 0) :
                                       ($urandom_range(0, 7) != 0);
            @(negedge clock);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t unexpected word: actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            exp_word = expected_q.pop_front();
            if (rsp_data.res_x !== exp_word.res_x || rsp_data.res_y !== exp_word.res_y ||
                rsp_data.res_z !== exp_word.res_z || rsp_data.equal !== exp_word.equal ||
                rsp_data.distance !== exp_word.distance ||
                rsp_data.div_by_zero !== exp_word.div_by_zero) begin
               $display("%0t mismatch: expected %h actual %h", $time, exp_word, rsp_data);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles with no word accepted on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("vector3_alu_with_distance regression: fail");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (expected_q.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("vector3_alu_with_distance regression: pass");
      else
         $display("vector3_alu_with_distance regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
sv/vad_pkg.sv
sv/vad_prep.sv
sv/vad_cell.sv
sv/vector3_alu_with_distance.sv
verif/tb.sv
